>>> hdl/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// Opcodes, field codes and the expansion function for the RV32C expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

    // Widths of the compressed and the expanded instruction.
    localparam int unsigned HALF_W = 16;
    localparam int unsigned WORD_W = 32;

    typedef logic [HALF_W-1:0] t_half;
    typedef logic [WORD_W-1:0] t_word;

    // RV32I major opcodes.
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_SYS    = 7'h73;

    // RV32I funct3 and funct7 codes.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [6:0] F7_NONE = 7'h00;
    localparam logic [6:0] F7_SUB  = 7'h20;
    localparam logic [6:0] F7_SRA  = 7'h20;

    // Architectural registers with a fixed role.
    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_RA   = 5'd1;
    localparam logic [4:0] REG_SP   = 5'd2;

    // Compressed quadrants.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    // Compressed funct3 codes, quadrant 0.
    localparam logic [2:0] C0_ADDI4SPN = 3'd0;
    localparam logic [2:0] C0_LW       = 3'd2;
    localparam logic [2:0] C0_SW       = 3'd6;
    // Quadrant 1.
    localparam logic [2:0] C1_ADDI     = 3'd0;
    localparam logic [2:0] C1_JAL      = 3'd1;
    localparam logic [2:0] C1_LI       = 3'd2;
    localparam logic [2:0] C1_LUI      = 3'd3;
    localparam logic [2:0] C1_ALU      = 3'd4;
    localparam logic [2:0] C1_J        = 3'd5;
    localparam logic [2:0] C1_BEQZ     = 3'd6;
    localparam logic [2:0] C1_BNEZ     = 3'd7;
    // Quadrant 2.
    localparam logic [2:0] C2_SLLI     = 3'd0;
    localparam logic [2:0] C2_LWSP     = 3'd2;
    localparam logic [2:0] C2_CR       = 3'd4;
    localparam logic [2:0] C2_SWSP     = 3'd6;

    // Sub-operation in bits 11:10 of the quadrant 1 ALU group.
    localparam logic [1:0] ALU_SRLI = 2'd0;
    localparam logic [1:0] ALU_SRAI = 2'd1;
    localparam logic [1:0] ALU_ANDI = 2'd2;
    // Register-register operation in bits 6:5.
    localparam logic [1:0] RR_SUB = 2'd0;
    localparam logic [1:0] RR_XOR = 2'd1;
    localparam logic [1:0] RR_OR  = 2'd2;

    function automatic t_word form_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                     logic [4:0] rs1, logic [11:0] imm);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic t_word form_r(logic [4:0] rd, logic [2:0] f3, logic [4:0] rs1,
                                     logic [4:0] rs2, logic [6:0] f7);
        return {f7, rs2, rs1, f3, rd, OPC_REG};
    endfunction

    function automatic t_word form_s(logic [4:0] rs1, logic [4:0] rs2, logic [11:0] imm);
        return {imm[11:5], rs2, rs1, F3_WORD, imm[4:0], OPC_STORE};
    endfunction

    function automatic t_word form_b(logic [2:0] f3, logic [4:0] rs1, logic [12:0] imm);
        return {imm[12], imm[10:5], REG_ZERO, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
    endfunction

    function automatic t_word form_j(logic [4:0] rd, logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
    endfunction

    // Expands one halfword; the result is zero for unsupported and some reserved encodings.
    function automatic t_word expand(t_half h);
        logic [2:0]  fn;
        logic [4:0]  rdc;
        logic [4:0]  rsc;
        logic [4:0]  rfull;
        logic [4:0]  r2full;
        logic [11:0] imm6;
        logic [20:0] jimm;
        logic [12:0] bimm;
        logic [11:0] wofs;
        logic [11:0] spn_imm;
        logic [11:0] sp16_imm;
        logic [11:0] lwsp_imm;
        logic [11:0] swsp_imm;
        logic [11:0] shamt;
        t_word       w;

        fn       = h[15:13];
        rdc      = {2'b01, h[9:7]};
        rsc      = {2'b01, h[4:2]};
        rfull    = h[11:7];
        r2full   = h[6:2];
        imm6     = {{7{h[12]}}, h[6:2]};
        jimm     = {{10{h[12]}}, h[8], h[10:9], h[6], h[7], h[2], h[11], h[5:3], 1'b0};
        bimm     = {{5{h[12]}}, h[6:5], h[2], h[11:10], h[4:3], 1'b0};
        wofs     = {5'd0, h[5], h[12:10], h[6], 2'b00};
        spn_imm  = {2'b00, h[10:7], h[12:11], h[5], h[6], 2'b00};
        sp16_imm = {{3{h[12]}}, h[4:3], h[5], h[2], h[6], 4'd0};
        lwsp_imm = {4'd0, h[3:2], h[12], h[6:4], 2'b00};
        swsp_imm = {4'd0, h[8:7], h[12:9], 2'b00};
        // Shift amount bit 5 (instruction bit 12) is dropped.
        shamt    = {7'd0, h[6:2]};
        w        = '0;

        unique case (h[1:0])
            QUAD_0: begin
                unique case (fn)
                    C0_ADDI4SPN: begin
                        if (spn_imm != '0) begin
                            w = form_i(OPC_IMM, rsc, F3_ADD, REG_SP, spn_imm);
                        end
                    end
                    C0_LW:   w = form_i(OPC_LOAD, rsc, F3_WORD, rdc, wofs);
                    C0_SW:   w = form_s(rdc, rsc, wofs);
                    default: w = '0;
                endcase
            end
            QUAD_1: begin
                unique case (fn)
                    C1_ADDI: w = form_i(OPC_IMM, rfull, F3_ADD, rfull, imm6);
                    C1_JAL:  w = form_j(REG_RA, jimm);
                    C1_LI:   w = form_i(OPC_IMM, rfull, F3_ADD, REG_ZERO, imm6);
                    C1_LUI: begin
                        if (rfull == REG_SP) begin
                            if (sp16_imm != '0) begin
                                w = form_i(OPC_IMM, REG_SP, F3_ADD, REG_SP, sp16_imm);
                            end
                        end else if ({h[12], h[6:2]} != '0) begin
                            w = {{14{h[12]}}, h[12], h[6:2], rfull, OPC_LUI};
                        end
                    end
                    C1_ALU: begin
                        unique case (h[11:10])
                            ALU_SRLI: w = form_i(OPC_IMM, rdc, F3_SR, rdc, shamt);
                            ALU_SRAI: w = form_i(OPC_IMM, rdc, F3_SR, rdc,
                                                 {F7_SRA, 5'd0} | shamt);
                            ALU_ANDI: w = form_i(OPC_IMM, rdc, F3_AND, rdc, imm6);
                            default: begin
                                // Bit 12 set marks the RV64 word forms.
                                if (!h[12]) begin
                                    unique case (h[6:5])
                                        RR_SUB:  w = form_r(rdc, F3_ADD, rdc, rsc, F7_SUB);
                                        RR_XOR:  w = form_r(rdc, F3_XOR, rdc, rsc, F7_NONE);
                                        RR_OR:   w = form_r(rdc, F3_OR, rdc, rsc, F7_NONE);
                                        default: w = form_r(rdc, F3_AND, rdc, rsc, F7_NONE);
                                    endcase
                                end
                            end
                        endcase
                    end
                    C1_J:    w = form_j(REG_ZERO, jimm);
                    C1_BEQZ: w = form_b(F3_BEQ, rdc, bimm);
                    default: w = form_b(F3_BNE, rdc, bimm);
                endcase
            end
            QUAD_2: begin
                unique case (fn)
                    C2_SLLI: w = form_i(OPC_IMM, rfull, F3_SLL, rfull, shamt);
                    C2_LWSP: w = form_i(OPC_LOAD, rfull, F3_WORD, REG_SP, lwsp_imm);
                    C2_CR: begin
                        if (!h[12]) begin
                            if (r2full != REG_ZERO) begin
                                w = form_r(rfull, F3_ADD, REG_ZERO, r2full, F7_NONE);
                            end else begin
                                w = form_i(OPC_JALR, REG_ZERO, F3_ADD, rfull, 12'd0);
                            end
                        end else if (rfull == REG_ZERO && r2full == REG_ZERO) begin
                            // Breakpoint.
                            w = form_i(OPC_SYS, REG_ZERO, F3_ADD, REG_ZERO, 12'd1);
                        end else if (r2full != REG_ZERO) begin
                            w = form_r(rfull, F3_ADD, rfull, r2full, F7_NONE);
                        end else begin
                            w = form_i(OPC_JALR, REG_RA, F3_ADD, rfull, 12'd0);
                        end
                    end
                    C2_SWSP: w = form_s(REG_SP, r2full, swsp_imm);
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hdl/rvc_compressed_expander.sv
// ----------------------------------------------------------------------------
// rvc_compressed_expander
// Expands one RV32C halfword into its 32-bit RV32I instruction.
// ----------------------------------------------------------------------------
// The block takes one halfword per cycle while the consumer keeps up and
// returns the expanded word from the result register: the halfword is
// captured in an input register, decoded by a single pass of combinational
// logic and captured in the result register. Both stages advance together
// whenever the result register is free or being emptied, so a new halfword
// is taken in every cycle that the consumer keeps up. Unsupported and some
// reserved encodings, quadrant 3 included, give zero with the illegal flag set.
`default_nettype none

module rvc_compressed_expander
    import rvc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [HALF_W-1:0] i_half_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [WORD_W-1:0]      o_expanded_word,
    output logic                   o_illegal
);

    logic  r_in_valid;
    t_half r_half;
    logic  r_out_valid;
    t_word r_word;
    logic  r_illegal;

    t_word n_word;
    logic  out_free;

    // The result register can take new data when empty or being emptied.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || out_free;

    always_comb begin
        n_word = expand(r_half);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_half <= i_half_word;
        end
        if (out_free && r_in_valid) begin
            r_word    <= n_word;
            // No legal expansion is ever the zero word.
            r_illegal <= (n_word == '0);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_expanded_word = r_word;
    assign o_illegal       = r_illegal;

endmodule

`default_nettype wire
